>>> src/text_to_int32_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Text-to-int32 parser assertion macros
// Shared concurrent assertion shorthands for the parser modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INT32_PARSER_UNIT_MACROS_SVH
`define TEXT_TO_INT32_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TTIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TTIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ttip_pkg.sv
// ----------------------------------------------------------------------------
// Text-to-int32 parser package
// Widths, character codes, bases and the beat structures of the parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

    localparam int CH_W        = 8;
    localparam int BASE_W      = 6;
    localparam int VALUE_W     = 32;
    localparam int END_W       = 16;
    localparam int OFFSET_BITS = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 48;
    localparam int PROD_W      = VALUE_W + BASE_W;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_NEG_MIN = 32'h8000_0000;

    // Character codes.
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

    // Base codes.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic              start_req;
        logic [BASE_W-1:0] base;
    } t_in_beat;

    typedef struct packed {
        logic              is_alnum;
        logic [BASE_W-1:0] digit;
        logic              is_space;
        logic              is_plus;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
    } t_char_info;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [END_W-1:0]          end_offset;
        logic                      range_error;
        logic                      converted;
    } t_result;

endpackage

>>> src/text_to_int32_parser_unit.sv
// ----------------------------------------------------------------------------
// Text-to-int32 parser unit
// Streaming string-to-integer converter with a signed 32-bit clamped result.
// ----------------------------------------------------------------------------
// The unit takes one text byte per beat and returns one result beat per
// string, on the byte that ends the number. A beat with tuser set begins a
// string and carries the base (0 for automatic, else 2 to 36). Leading
// whitespace and one sign are skipped, a 0x or 0X prefix selects base 16 for
// base 0 or 16, and base 0 otherwise chooses octal after a leading zero and
// decimal in every other case. A beat without tuser while no string is open
// is dropped, and a new start abandons an open string without a result. The
// unit accepts one byte in every cycle unless a held result stalls it; a
// result beat is registered after its terminating byte has passed the input
// register stage. The cycle time is set by the accumulator loop: one 32 by 6
// bit multiply-add and a compare against the signed limit.
// ----------------------------------------------------------------------------
module text_to_int32_parser_unit
    import ttip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream: one text byte per beat.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] ch, [13:8] base, [15:14] zero
    input  logic                  i_s_tuser,   // [0] start_req
    // Result stream: one beat per finished string.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] value, [47:32] end_offset
    output logic [1:0]            o_m_tuser    // [0] range_error, [1] converted
);

    // Input register stage.
    logic       r_in_valid;
    t_in_beat   r_in;
    // Result register stage.
    logic       r_out_valid;
    t_result    r_out;

    logic       step;
    logic       emit;
    t_char_info info;
    t_result    result;

    // The input stage moves on whenever the result register is free or is
    // being emptied in this cycle, so bytes flow at one per cycle.
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.ch        <= i_s_tdata[CH_W-1:0];
            r_in.base      <= i_s_tdata[CH_W+BASE_W-1:CH_W];
            r_in.start_req <= i_s_tuser;
        end
    end

    ttip_char_class u_char_class (
        .i_ch   (r_in.ch),
        .o_info (info)
    );

    ttip_parse_core u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in),
        .i_info   (info),
        .o_emit   (emit),
        .o_result (result)
    );

    // The result register holds a finished beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.end_offset, r_out.value};
    assign o_m_tuser  = {r_out.converted, r_out.range_error};

endmodule

>>> src/ttip_char_class.sv
// ----------------------------------------------------------------------------
// Text-to-int32 parser character classifier
// Decodes one text byte into its digit value and the punctuation classes.
// ----------------------------------------------------------------------------
module ttip_char_class
    import ttip_pkg::*;
(
    input  logic [CH_W-1:0] i_ch,
    output t_char_info      o_info
);

    logic is_num;
    logic is_upper;
    logic is_lower;

    assign is_num   = (i_ch >= CH_ZERO)    && (i_ch <= CH_NINE);
    assign is_upper = (i_ch >= CH_UPPER_A) && (i_ch <= CH_UPPER_Z);
    assign is_lower = (i_ch >= CH_LOWER_A) && (i_ch <= CH_LOWER_Z);

    always_comb begin
        o_info          = '0;
        o_info.is_alnum = is_num || is_upper || is_lower;
        if (is_num) begin
            o_info.digit = BASE_W'(i_ch - CH_ZERO);
        end else if (is_upper) begin
            o_info.digit = BASE_W'(i_ch - CH_UPPER_A + LETTER_OFS);
        end else if (is_lower) begin
            o_info.digit = BASE_W'(i_ch - CH_LOWER_A + LETTER_OFS);
        end
        // Whitespace is tab to carriage return, plus the space itself.
        o_info.is_space = ((i_ch >= CH_TAB) && (i_ch <= CH_CR)) || (i_ch == CH_SPACE);
        o_info.is_plus  = (i_ch == CH_PLUS);
        o_info.is_minus = (i_ch == CH_MINUS);
        o_info.is_zero  = (i_ch == CH_ZERO);
        o_info.is_x     = (i_ch == CH_LOWER_X) || (i_ch == CH_UPPER_X);
    end

endmodule

>>> src/ttip_parse_core.sv
// ----------------------------------------------------------------------------
// Text-to-int32 parser core
// Parse state, accumulator with clamping, and the result of a finished string.
// ----------------------------------------------------------------------------
`include "text_to_int32_parser_unit_macros.svh"

module ttip_parse_core
    import ttip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_beat   i_beat,
    input  t_char_info i_info,
    output logic       o_emit,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_AFTERX = 3'd4,
        PH_DIGITS = 3'd5
    } t_phase;

    t_phase                 r_phase,    n_phase;
    logic                   r_neg,      n_neg;
    logic [BASE_W-1:0]      r_base,     n_base;
    logic [VALUE_W-1:0]     r_acc,      n_acc;
    logic                   r_ovf,      n_ovf;
    logic                   r_seen,     n_seen;
    logic [OFFSET_BITS-1:0] r_position, n_position;

    t_phase              cur_phase;
    logic                cur_neg;
    logic [BASE_W-1:0]   cur_base;
    logic [VALUE_W-1:0]  cur_acc;
    logic                cur_ovf;
    logic                cur_seen;
    logic [BASE_W-1:0]   eff_base;
    logic                do_digit;
    logic                first_char;
    logic                emit;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   limit;
    logic [VALUE_W-1:0]  value;

    // A start beat works on freshly cleared state.
    always_comb begin
        if (i_beat.start_req) begin
            cur_phase  = PH_LEAD;
            cur_neg    = 1'b0;
            cur_base   = i_beat.base;
            cur_acc    = '0;
            cur_ovf    = 1'b0;
            cur_seen   = 1'b0;
            n_position = '0;
        end else begin
            cur_phase  = r_phase;
            cur_neg    = r_neg;
            cur_base   = r_base;
            cur_acc    = r_acc;
            cur_ovf    = r_ovf;
            cur_seen   = r_seen;
            n_position = (r_position < POS_MAX) ? r_position + 1'b1 : r_position;
        end
    end

    assign product = PROD_W'(cur_acc) * PROD_W'(eff_base) + PROD_W'(i_info.digit);
    assign limit   = n_neg ? PROD_W'(VALUE_NEG_MIN) : PROD_W'(VALUE_POS_MAX);

    always_comb begin
        n_phase    = cur_phase;
        n_neg      = cur_neg;
        n_acc      = cur_acc;
        n_ovf      = cur_ovf;
        n_seen     = cur_seen;
        eff_base   = cur_base;
        do_digit   = 1'b0;
        first_char = 1'b0;
        emit       = 1'b0;

        unique case (cur_phase)
            PH_LEAD: begin
                if (i_info.is_space) begin
                    n_phase = PH_LEAD;
                end else if (i_info.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_info.is_plus) begin
                    n_phase = PH_SIGNED;
                end else begin
                    first_char = 1'b1;
                end
            end
            PH_SIGNED: begin
                first_char = 1'b1;
            end
            PH_ZERO: begin
                if (i_info.is_x) begin
                    eff_base = BASE_HEX;
                    n_phase  = PH_AFTERX;
                end else begin
                    // The leading zero counts as a digit; auto base becomes octal.
                    if (cur_base == BASE_AUTO) begin
                        eff_base = BASE_OCT;
                    end
                    n_seen   = 1'b1;
                    do_digit = 1'b1;
                end
            end
            PH_AFTERX, PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (first_char) begin
            if (i_info.is_zero && ((cur_base == BASE_AUTO) || (cur_base == BASE_HEX))) begin
                n_phase = PH_ZERO;
            end else begin
                if (cur_base == BASE_AUTO) begin
                    eff_base = BASE_DEC;
                end
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            if (!i_info.is_alnum || (i_info.digit >= eff_base)) begin
                emit    = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                n_seen  = 1'b1;
                n_phase = PH_DIGITS;
                if (!cur_ovf) begin
                    if (product > limit) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = product[VALUE_W-1:0];
                    end
                end
            end
        end

        n_base = eff_base;
    end

    // A beat while idle and without start is dropped.
    assign o_emit = i_step && emit && (i_beat.start_req || (r_phase != PH_IDLE));

    always_comb begin
        if (n_ovf) begin
            value = n_neg ? VALUE_NEG_MIN : VALUE_POS_MAX;
        end else if (n_neg) begin
            value = VALUE_W'(0) - n_acc;
        end else begin
            value = n_acc;
        end
        o_result.value       = value;
        o_result.end_offset  = n_seen ? END_W'(n_position) : '0;
        o_result.range_error = n_ovf;
        o_result.converted   = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_neg      <= 1'b0;
            r_base     <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_seen     <= 1'b0;
            r_position <= '0;
        end else if (i_step && (i_beat.start_req || (r_phase != PH_IDLE))) begin
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_base     <= n_base;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_seen     <= n_seen;
            r_position <= n_position;
        end
    end

    `TTIP_ASSERT_NEXT(a_emit_goes_idle, i_clk, i_rst_n, o_emit, r_phase == PH_IDLE, "parser not idle after a result")
    `TTIP_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf && !(i_step && i_beat.start_req), r_ovf, "overflow flag cleared within a string")
    `TTIP_ASSERT_NOW(a_empty_result, i_clk, i_rst_n, o_emit && !o_result.converted, (o_result.value == 0) && (o_result.end_offset == 0) && !o_result.range_error, "result without digits is not empty")

endmodule

>>> test/parser_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser result checker
// Watches both streams of the text-to-int32 parser, predicts every result
// beat from the accepted text bytes and compares it with the block's output.
// ----------------------------------------------------------------------------
module parser_result_checker
    import ttip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] ch, [13:8] base, [15:14] zero
    input  logic                  i_s_tuser,   // [0] start_req
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // [31:0] value, [47:32] end_offset
    input  logic [1:0]            i_m_tuser,   // [0] range_error, [1] converted
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int NO_DIGIT = 64;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_AFTER_X,
        SCAN_DIGITS
    } t_scan_phase;

    t_scan_phase            scan_phase;
    logic                   negative;
    logic [BASE_W-1:0]      radix;
    logic [VALUE_W-1:0]     magnitude;
    logic                   clamped;
    logic                   any_digit;
    logic [OFFSET_BITS-1:0] position;

    t_result expected_results[$];
    int      mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic take_digit(input int d);
        logic [63:0] next;
        logic [63:0] limit;
        any_digit = 1'b1;
        if (!clamped) begin
            limit = negative ? {32'd0, VALUE_NEG_MIN} : {32'd0, VALUE_POS_MAX};
            next  = {32'd0, magnitude} * 64'(radix) + 64'(d);
            if (next > limit) begin
                clamped = 1'b1;
            end else begin
                magnitude = next[VALUE_W-1:0];
            end
        end
        scan_phase = SCAN_DIGITS;
    endtask

    // Advances the parse by one byte; emit is set when the byte ends a number.
    task automatic scan_byte(input logic [CH_W-1:0] c, input logic st,
                             input logic [BASE_W-1:0] b,
                             output bit emit, output t_result res);
        int d;
        bit first;
        bit try_digit;
        emit      = 1'b0;
        res       = '0;
        first     = 1'b0;
        try_digit = 1'b0;
        if (st) begin
            scan_phase = SCAN_LEAD;
            negative   = 1'b0;
            radix      = b;
            magnitude  = '0;
            clamped    = 1'b0;
            any_digit  = 1'b0;
            position   = '0;
        end else begin
            if (scan_phase == SCAN_IDLE) return;
            if (position != POS_MAX) position = position + 1'b1;
        end

        case (scan_phase)
            SCAN_LEAD: begin
                if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
                    // Leading whitespace is skipped.
                end else if (c == CH_MINUS) begin
                    negative   = 1'b1;
                    scan_phase = SCAN_SIGNED;
                end else if (c == CH_PLUS) begin
                    scan_phase = SCAN_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            SCAN_SIGNED: begin
                first = 1'b1;
            end
            SCAN_ZERO: begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    radix      = BASE_HEX;
                    scan_phase = SCAN_AFTER_X;
                end else begin
                    if (radix == BASE_AUTO) radix = BASE_OCT;
                    take_digit(0);
                    try_digit = 1'b1;
                end
            end
            SCAN_AFTER_X, SCAN_DIGITS: begin
                try_digit = 1'b1;
            end
            default: begin
                scan_phase = SCAN_IDLE;
            end
        endcase

        if (first) begin
            if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
                scan_phase = SCAN_ZERO;
            end else begin
                if (radix == BASE_AUTO) radix = BASE_DEC;
                try_digit = 1'b1;
            end
        end

        if (try_digit) begin
            if (c >= CH_ZERO && c <= CH_NINE) d = int'(c - CH_ZERO);
            else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) d = int'(c - CH_UPPER_A + LETTER_OFS);
            else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) d = int'(c - CH_LOWER_A + LETTER_OFS);
            else d = NO_DIGIT;
            if (d >= int'(radix)) begin
                if (clamped) res.value = negative ? VALUE_NEG_MIN : VALUE_POS_MAX;
                else         res.value = negative ? -magnitude : magnitude;
                res.end_offset  = any_digit ? position[END_W-1:0] : '0;
                res.range_error = clamped;
                res.converted   = any_digit;
                scan_phase      = SCAN_IDLE;
                emit            = 1'b1;
            end else begin
                take_digit(d);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        bit      emit;
        if (!i_rst_n) begin
            scan_phase = SCAN_IDLE;
            negative   = 1'b0;
            radix      = '0;
            magnitude  = '0;
            clamped    = 1'b0;
            any_digit  = 1'b0;
            position   = '0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                scan_byte(i_s_tdata[CH_W-1:0], i_s_tuser, i_s_tdata[CH_W+BASE_W-1:CH_W],
                          emit, want);
                if (emit) expected_results.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value       = i_m_tdata[VALUE_W-1:0];
                got.end_offset  = i_m_tdata[VALUE_W+END_W-1:VALUE_W];
                got.range_error = i_m_tuser[0];
                got.converted   = i_m_tuser[1];
                if (expected_results.size() == 0) begin
                    $error("result beat with no string awaiting a result");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, got.value);
                        mismatches++;
                    end
                    if (got.end_offset !== want.end_offset) begin
                        $error("end_offset: expected %0d, actual %0d",
                               want.end_offset, got.end_offset);
                        mismatches++;
                    end
                    if (got.range_error !== want.range_error) begin
                        $error("range_error: expected %0b, actual %0b",
                               want.range_error, got.range_error);
                        mismatches++;
                    end
                    if (got.converted !== want.converted) begin
                        $error("converted: expected %0b, actual %0b",
                               want.converted, got.converted);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-to-int32 parser testbench
// Streams directed and random text strings into the parser under random
// back-pressure and lets a separate checker predict and compare the results.
// ----------------------------------------------------------------------------
// The stimulus opens with a short directed part: a byte while no string is
// open, a string abandoned by a new start, a hexadecimal prefix with no digit
// after it, the odd bases 1 and 63, and a clamped negative value with digits
// beyond the overflow. The random part then sends mostly well-formed
// numbers with random whitespace, signs, prefixes, bases and digits, mixed
// with raw noise, broken strings and values at the edges of the 32-bit range.
// ----------------------------------------------------------------------------
module testbench;
    import ttip_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_BEATS = 820;
    // Random beats during which neither side idles.
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 450;
    // Beat after which the receiver holds off to fill the block up.
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    // Slack after the last expected result, in which nothing more may come out.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;    // [7:0] ch, [13:8] base, [15:14] zero
    logic                  s_tuser  = 1'b0;  // [0] start_req
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [31:0] value, [47:32] end_offset
    logic [1:0]            m_tuser;          // [0] range_error, [1] converted

    int fail_count;
    int pending;

    // Shared between the sender and the receiver: calm switches idling off on
    // both sides, hold_wanted asks the receiver for its long hold-off.
    bit calm        = 1'b0;
    bit hold_wanted = 1'b0;

    // Bytes sent as part of strings, and the text of the string being built.
    int              string_beats = 0;
    logic [CH_W-1:0] text[$];

    always #HALF_PERIOD i_clk = ~i_clk;

    text_to_int32_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    parser_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one byte and returns at the edge at which the beat is taken.
    // Random idle cycles go in front of the beat unless the run is calm. The
    // valid is only lowered inside the idle loop, so a beat that follows
    // straight on keeps it high without a glitch in the same time step.
    task automatic send_byte(input logic [CH_W-1:0] c, input logic st,
                             input logic [BASE_W-1:0] b);
        if (!calm) begin
            while ($urandom_range(0, 99) < 37) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, c};
        s_tuser  <= st;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Sends the current text as one string: the first byte carries the start
    // flag and the base, and the base bits of the others are random, since
    // the block must ignore them.
    task automatic send_text(input logic [BASE_W-1:0] b);
        for (int i = 0; i < text.size(); i++) begin
            send_byte(text[i], i == 0, (i == 0) ? b : BASE_W'($urandom_range(0, 63)));
            string_beats++;
        end
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    // Character for a digit value, letters in either case.
    function automatic logic [CH_W-1:0] digit_char(input int d);
        if (d < 10) return CH_W'(CH_ZERO + d);
        return CH_W'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + d - LETTER_OFS);
    endfunction

    // A byte to close a number; the last choice is any byte at all, which
    // may well carry the number on instead.
    function automatic logic [CH_W-1:0] end_byte();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return ";";
            2: return 8'h00;
            3: return CH_W'($urandom_range(128, 255));
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds a well-formed number: optional whitespace, sign and prefix,
    // then digits below the base in use, then a closing byte.
    task automatic build_number(output logic [BASE_W-1:0] b);
        int pick;
        int radix;
        int digits;
        pick = $urandom_range(0, 99);
        if (pick < 35)      b = BASE_AUTO;
        else if (pick < 55) b = BASE_HEX;
        else if (pick < 65) b = BASE_DEC;
        else if (pick < 75) b = BASE_OCT;
        else if (pick < 95) b = BASE_W'($urandom_range(2, 36));
        else                b = BASE_W'($urandom_range(0, 63));
        text.delete();
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) begin
                text.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE
                                                           : CH_W'(CH_TAB + $urandom_range(0, 4)));
            end
        end
        case ($urandom_range(0, 2))
            0: text.push_back(CH_MINUS);
            1: text.push_back(CH_PLUS);
            default: ;
        endcase
        radix = int'(b);
        if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) == 0) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            radix = BASE_HEX;
        end else if (b == BASE_AUTO) begin
            radix = BASE_DEC;
            if ($urandom_range(0, 3) == 0) begin
                text.push_back(CH_ZERO);
                radix = BASE_OCT;
            end
        end
        // Mostly short numbers, now and then long enough to overflow.
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 8);
        repeat (digits) begin
            text.push_back(digit_char($urandom_range(0, ((radix > 36) ? 36 : radix) - 1)));
        end
        text.push_back(end_byte());
    endtask

    initial begin : stimulus
        logic [BASE_W-1:0] b;
        int                kind;
        int                rand_base;
        int                n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A byte without a start while no string is open is dropped.
        send_byte("Z", 1'b0, BASE_HEX);
        // This string stays open and is abandoned by the next start, which
        // brings a hexadecimal prefix with no digit after it.
        load_text("\t+12");
        send_text(BASE_DEC);
        load_text("0xg");
        send_text(BASE_HEX);
        // Base 1 takes only a zero; base 63 takes every letter.
        load_text("01");
        send_text(6'd1);
        load_text("z~");
        send_text(6'd63);
        // Negative overflow in base 36, with digits past the overflow and a
        // closing byte that has its top bit set.
        load_text("-zzzzzzz");
        text.push_back(8'hFF);
        send_text(6'd36);

        rand_base = string_beats;
        while (string_beats - rand_base < RANDOM_BEATS) begin
            n    = string_beats - rand_base;
            calm = (n >= CALM_FROM && n < CALM_TO);
            if (n >= HOLD_AT) hold_wanted = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                // Loose bytes with no start: dropped, or they run on in the
                // string left open before them.
                repeat ($urandom_range(1, 4)) begin
                    send_byte(CH_W'($urandom_range(0, 255)), 1'b0,
                              BASE_W'($urandom_range(0, 63)));
                end
            end else if (kind < 16) begin
                // Broken strings of raw bytes under any base.
                text.delete();
                repeat ($urandom_range(1, 8)) text.push_back(CH_W'($urandom_range(0, 255)));
                send_text(BASE_W'($urandom_range(0, 63)));
            end else if (kind < 22) begin
                // Values at and just beyond the limits of the 32-bit range.
                case ($urandom_range(0, 5))
                    0: begin
                        load_text("2147483647");
                        b = BASE_DEC;
                    end
                    1: begin
                        load_text("2147483648");
                        b = BASE_DEC;
                    end
                    2: begin
                        load_text("-2147483648");
                        b = BASE_DEC;
                    end
                    3: begin
                        load_text("-2147483649");
                        b = BASE_DEC;
                    end
                    4: begin
                        load_text("0x7fffffff");
                        b = BASE_AUTO;
                    end
                    default: begin
                        load_text(" -0X80000001");
                        b = BASE_AUTO;
                    end
                endcase
                text.push_back(end_byte());
                send_text(b);
            end else begin
                build_number(b);
                send_text(b);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Let the checker take in the last beat, wait for the last results,
        // then give the block a few more cycles in which nothing further may
        // come out.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random back-pressure, none while the run is calm, and one
    // long hold-off of its own counting once the sender asks for it, so that
    // results pile up inside the block and its input stalls.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                for (int i = 0; i < HOLD_CYCLES; i++) begin
                    m_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 37);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule
